// ----- hw/rtl/sliding_window_median_top_macros.svh -----
// ----------------------------------------------------------------------------
// Sliding window median assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define SWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define SWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared constants, the controller state type and the cell control bundle.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Width and reset value of the window length register.
    localparam int             CFG_W     = 6;
    localparam logic [CFG_W-1:0] LEN_RESET = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } t_state;

    // Control bundle broadcast from the controller to every cell.
    typedef struct packed {
        logic wr;    // write the incoming sample into the addressed cell
        logic load;  // copy stored values into the rotating chain, clear ranks
        logic run;   // compare against the passing value, then rotate
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/swm_cell.sv -----
// ----------------------------------------------------------------------------
// Sliding window median cell
// Holds one ring entry and counts how many window entries sort below it while
// a copy of every entry rotates past through the chain.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int INDEX       = 0,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_W       = 5,
    parameter int LEN_W       = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swm_pkg::t_cell_ctrl           i_ctrl,
    input  logic [IDX_W-1:0]              i_wr_idx,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [LEN_W-1:0]              i_len,
    input  logic [IDX_W-1:0]              i_target,
    input  logic signed [SAMPLE_BITS-1:0] i_m_val,
    input  logic [IDX_W-1:0]              i_m_tag,
    output logic signed [SAMPLE_BITS-1:0] o_m_val,
    output logic [IDX_W-1:0]              o_m_tag,
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output logic                          o_hit
);

    logic signed [SAMPLE_BITS-1:0] r_val;
    logic signed [SAMPLE_BITS-1:0] r_m_val;
    logic [IDX_W-1:0]              r_m_tag;
    logic [IDX_W-1:0]              r_rank;

    logic w_active;
    logic w_m_active;
    logic w_below;

    assign w_active   = LEN_W'(INDEX) < i_len;
    assign w_m_active = LEN_W'(r_m_tag) < i_len;

    // Ties are broken by ring position so that every rank is unique.
    assign w_below = w_active && w_m_active &&
                     ((r_m_val < r_val) || ((r_m_val == r_val) && (r_m_tag < IDX_W'(INDEX))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_ctrl.wr && (i_wr_idx == IDX_W'(INDEX))) begin
            r_val <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_m_val <= r_val;
            r_m_tag <= IDX_W'(INDEX);
            r_rank  <= '0;
        end else if (i_ctrl.run) begin
            r_m_val <= i_m_val;
            r_m_tag <= i_m_tag;
            r_rank  <= r_rank + IDX_W'(w_below);
        end
    end

    assign o_m_val = r_m_val;
    assign o_m_tag = r_m_tag;
    assign o_val   = r_val;
    assign o_hit   = w_active && (r_rank == i_target);

endmodule

// ----- hw/rtl/sliding_window_median_top.sv -----
// ----------------------------------------------------------------------------
// Sliding window median filter
// Running median over the most recent window_len samples, built as a ring of
// rank-counting cells.
//
//   Channel   Direction  Word contents (low bit up)
//   s_axis    in         tdata: sample, zero padded to whole bytes
//   m_axis    out        tdata: median, zero padded to whole bytes
//   cfg       in         i_cfg_wr_data: window_len
//
// After a sample is accepted, the controller loads the rotating chain, then
// runs WINDOW_MAX rotation steps so every cell sees every entry, then selects
// the median into the output register. A new sample is taken only after that
// median has been loaded, so the input waits for the rotation and a stall.
// Reset clears the window to zeros, the ring pointer to zero and the length
// to 32. A stalled output holds its word while the next sample is processed.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // [SAMPLE_BITS-1:0] median
    input  logic                          i_cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]     i_cfg_wr_data
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int EXT_W  = (LEN_W > swm_pkg::CFG_W) ? LEN_W : swm_pkg::CFG_W;

    swm_pkg::t_state r_state;
    swm_pkg::t_state n_state;

    logic [swm_pkg::CFG_W-1:0] r_window_len;
    logic [IDX_W-1:0]          r_ptr;
    logic [IDX_W-1:0]          n_ptr;
    logic [IDX_W-1:0]          r_cnt;
    logic [SAMPLE_BITS-1:0]    r_out_data;
    logic                      r_out_valid;

    logic                      w_accept;
    logic                      w_out_load;
    logic                      w_last_step;
    swm_pkg::t_cell_ctrl       w_ctrl;
    logic [EXT_W-1:0]          w_len_ext;
    logic [LEN_W-1:0]          w_len;
    logic [LEN_W-1:0]          w_half;
    logic [IDX_W-1:0]          w_target;
    logic [IDX_W-1:0]          w_wr_idx;
    logic [LEN_W-1:0]          w_wr_inc;
    logic [SAMPLE_BITS-1:0]    w_median;

    logic signed [SAMPLE_BITS-1:0] w_m_val [WINDOW_MAX];
    logic [IDX_W-1:0]              w_m_tag [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_val   [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]         w_hit;

    // Length zero behaves as one; lengths above the cell count use them all.
    assign w_len_ext = EXT_W'(r_window_len);
    always_comb begin
        if (w_len_ext == '0) begin
            w_len = LEN_W'(1);
        end else if (w_len_ext > EXT_W'(WINDOW_MAX)) begin
            w_len = LEN_W'(WINDOW_MAX);
        end else begin
            w_len = w_len_ext[LEN_W-1:0];
        end
    end

    assign w_half   = w_len >> 1;
    assign w_target = w_half[IDX_W-1:0];

    // A pointer left beyond a shortened window restarts at the first entry.
    assign w_wr_idx = (LEN_W'(r_ptr) >= w_len) ? '0 : r_ptr;
    assign w_wr_inc = LEN_W'(w_wr_idx) + LEN_W'(1);
    assign n_ptr    = (w_wr_inc >= w_len) ? '0 : w_wr_inc[IDX_W-1:0];

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_last_step = (r_cnt == IDX_W'(WINDOW_MAX - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = swm_pkg::ST_LOAD;
                end
            end
            swm_pkg::ST_LOAD: begin
                n_state = swm_pkg::ST_RUN;
            end
            swm_pkg::ST_RUN: begin
                if (w_last_step) begin
                    n_state = swm_pkg::ST_DONE;
                end
            end
            swm_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        s_axis_tready = 1'b0;
        w_ctrl        = '0;
        w_out_load    = 1'b0;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_ctrl.wr     = s_axis_tvalid;
            end
            swm_pkg::ST_LOAD: begin
                w_ctrl.load = 1'b1;
            end
            swm_pkg::ST_RUN: begin
                w_ctrl.run = 1'b1;
            end
            swm_pkg::ST_DONE: begin
                w_out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= swm_pkg::ST_IDLE;
            r_window_len <= swm_pkg::LEN_RESET;
            r_ptr        <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_window_len <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_ptr <= n_ptr;
            end
            if (w_ctrl.run) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_median;
        end
    end

    // The ring of cells; the rotating copy moves one cell up each step.
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        localparam int PREV = (k == 0) ? WINDOW_MAX - 1 : k - 1;

        swm_cell #(
            .INDEX       (k),
            .SAMPLE_BITS (SAMPLE_BITS),
            .IDX_W       (IDX_W),
            .LEN_W       (LEN_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_wr_idx (w_wr_idx),
            .i_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
            .i_len    (w_len),
            .i_target (w_target),
            .i_m_val  (w_m_val[PREV]),
            .i_m_tag  (w_m_tag[PREV]),
            .o_m_val  (w_m_val[k]),
            .o_m_tag  (w_m_tag[k]),
            .o_val    (w_val[k]),
            .o_hit    (w_hit[k])
        );
    end

    // Exactly one active cell holds the target rank.
    always_comb begin
        w_median = '0;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            w_median = w_median | ({SAMPLE_BITS{w_hit[k]}} & w_val[k]);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'(r_out_data);

endmodule

// ----- hw/rtl/swm_checker.sv -----
// ----------------------------------------------------------------------------
// Sliding window median checker
// Port-level properties of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_median_top_macros.svh"

module swm_checker #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata
);

    logic w_in_acc;
    logic w_out_stall;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;

    // A word in the output register waits until it is taken.
    `SWM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_stall, m_axis_tvalid, "output word dropped")

    `SWM_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, w_out_stall, $stable(m_axis_tdata), "stalled output word changed")

    // After a sample is taken, the input side must still be closed once the rotation has ended.
    `SWM_ASSERT_IMP(a_busy_end, i_clk, i_rst_n, w_in_acc, ##(WINDOW_MAX + 2) !s_axis_tready, "input reopened before the rotation ended")

    // A new median only appears at the end of a busy period.
    `SWM_ASSERT_IMP(a_new_word, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready), "median appeared without a finished rotation")

endmodule

bind sliding_window_median_top swm_checker #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (.*);
